// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define FBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FBT_ASSERT(lbl, prop, msg)
`define FBT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/fbt_pkg.sv -----
package fbt_pkg;

  localparam int unsigned TAPS_DEF        = 33;
  localparam int unsigned FACTOR_DEF      = 3;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned COEF_W      = 17;
  localparam int unsigned COEF_FRAC   = 17;
  localparam int unsigned COEF_COUNT  = 33;
  localparam int unsigned COEF_ADDR_W = $clog2(COEF_COUNT);
  localparam int unsigned COEF_IDX_W  = 7;

  localparam logic signed [COEF_W-1:0] COEF_ROM [COEF_COUNT] = '{
    17'sd56,    17'sd195,   17'sd199,   -17'sd166,  -17'sd762,  -17'sd928,
    17'sd0,     17'sd1747,  17'sd2741,  17'sd1178,  -17'sd2954, -17'sd6675,
    -17'sd5320, 17'sd3969,  17'sd19151, 17'sd33449, 17'sd39309,
    17'sd33449, 17'sd19151, 17'sd3969,  -17'sd5320, -17'sd6675, -17'sd2954,
    17'sd1178,  17'sd2741,  17'sd1747,  17'sd0,     -17'sd928,  -17'sd762,
    -17'sd166,  17'sd199,   17'sd195,   17'sd56
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } fbt_state_e;

  typedef struct packed {
    logic clr;
    logic issue;
  } fbt_mac_ctrl_t;

  // taps beyond the table weigh zero
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (idx < COEF_IDX_W'(COEF_COUNT)) begin
      c = COEF_ROM[idx[COEF_ADDR_W-1:0]];
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/fbt_cell.sv -----
module fbt_cell import fbt_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] d_i,
  output logic signed [SAMPLE_BITS-1:0] q_o
);

  logic signed [SAMPLE_BITS-1:0] q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (en_i) begin
      q_q <= d_i;
    end
  end

  assign q_o = q_q;

endmodule

// ----- rtl/core/fbt_mac.sv -----
module fbt_mac import fbt_pkg::*; #(
  parameter int unsigned TAPS        = TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbt_mac_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [COEF_W-1:0]      coef_i,
  output logic signed [SAMPLE_BITS-1:0] result_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(TAPS) + 1;
  localparam int unsigned SH_W   = ACC_W + 1 - COEF_FRAC;

  localparam logic signed [ACC_W:0]  RND    = (ACC_W + 1)'(1) << (COEF_FRAC - 1);
  localparam logic signed [SH_W-1:0] SAT_HI = {{(SH_W - SAMPLE_BITS + 1){1'b0}},
                                              {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_LO = {{(SH_W - SAMPLE_BITS + 1){1'b1}},
                                              {(SAMPLE_BITS - 1){1'b0}}};

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [ACC_W:0]    rnd_sum;
  logic signed [ACC_W:0]    rnd_shift;
  logic signed [SH_W-1:0]   rounded;

  assign prod_d = PROD_W'(sample_i) * PROD_W'(coef_i);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // round half up to the sample grid, then clamp
  assign rnd_sum   = (ACC_W + 1)'(acc_q) + RND;
  assign rnd_shift = rnd_sum >>> COEF_FRAC;
  assign rounded   = rnd_shift[SH_W-1:0];

  always_comb begin
    if (rounded > SAT_HI) begin
      result_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rounded < SAT_LO) begin
      result_o = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result_o = rounded[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ----- rtl/core/fir_decimator_by_three_core.sv -----
// the transfer of every FACTOR-th input starts a run: ST_RUN visits every tap, then ST_DRAIN, then ST_FIN
//   registers the result once the output register is free; no input is taken until ST_IDLE again,
//   so the pace is set by the single multiply-accumulate unit that visits every tap of the sample ring
// inputs that emit no result are taken in ST_IDLE without leaving it
// reset: asynchronous active low, clears the sample ring, phase and handshake state
`include "assert_macros.svh"

module fir_decimator_by_three_core import fbt_pkg::*; #(
  parameter int unsigned TAPS        = TAPS_DEF,
  parameter int unsigned FACTOR      = FACTOR_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int unsigned TAP_W = $clog2(TAPS);
  localparam int unsigned PH_W  = $clog2(FACTOR);

  fbt_state_e state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic [PH_W-1:0]  phase_q, phase_d;
  logic             in_xfer;
  logic             last_phase;
  logic             load;
  logic             rotate;
  logic             out_load;
  fbt_mac_ctrl_t    mac_ctrl;

  logic signed [SAMPLE_BITS-1:0] cell_q [TAPS];
  logic signed [SAMPLE_BITS-1:0] head_d;
  logic signed [SAMPLE_BITS-1:0] result;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign last_phase = (phase_q == PH_W'(FACTOR - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && last_phase) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tap_q == '0) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    rotate         = 1'b0;
    out_load       = 1'b0;
    mac_ctrl.clr   = 1'b0;
    mac_ctrl.issue = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        mac_ctrl.clr = 1'b1;
      end
      ST_RUN: begin
        rotate         = 1'b1;
        mac_ctrl.issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FIN: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  assign load = in_xfer;

  always_comb begin
    tap_d   = tap_q;
    phase_d = phase_q;
    if (in_xfer) begin
      phase_d = last_phase ? '0 : phase_q + PH_W'(1);
      tap_d   = TAP_W'(TAPS - 1);
    end else if (rotate) begin
      tap_d = tap_q - TAP_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_out_q <= result;
    end
  end

  // sample ring: newest at the head, a full turn during the run restores the order
  assign head_d = load ? sample_in_i : cell_q[TAPS-1];

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    fbt_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (load || rotate),
      .d_i    ((i == 0) ? head_d : cell_q[(i == 0) ? 0 : i - 1]),
      .q_o    (cell_q[i])
    );
  end

  fbt_mac #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (cell_q[TAPS-1]),
    .coef_i   (coef_at(COEF_IDX_W'(tap_q))),
    .result_o (result)
  );

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  `FBT_ASSERT(a_start_run, in_xfer && last_phase |=> state_q == ST_RUN && tap_q == TAP_W'(TAPS - 1), "run did not start on the last phase")
  `FBT_ASSERT(a_run_end, state_q == ST_RUN && tap_q == '0 |=> state_q == ST_DRAIN, "run did not end after the last tap")
  `FBT_ASSERT(a_fin_out, state_q == ST_FIN && (!out_valid_q || out_ready_i) |=> out_valid_o && state_q == ST_IDLE, "result not posted")
  `FBT_ASSERT(a_no_in_busy, state_q != ST_IDLE |-> !in_xfer, "input transfer while busy")

endmodule

// ----- verif/tb.sv -----
module tb;

  localparam int unsigned TAPS         = fbt_pkg::TAPS_DEF;
  localparam int unsigned FACTOR       = fbt_pkg::FACTOR_DEF;
  localparam int unsigned SW           = fbt_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned FRAC_BITS    = 17;
  localparam int unsigned DRAIN_CYCLES = 2 * (TAPS + FACTOR + 2);
  localparam int unsigned LIMIT_CYCLES = 500000;

  localparam logic signed [SW-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SW-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum int unsigned {
    BURST_UNIFORM,
    BURST_EXTREME,
    BURST_MATCHED,
    BURST_SMALL
  } burst_kind_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic signed [SW-1:0] sample_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [SW-1:0] sample_out_o;

  fir_decimator_by_three_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  // filter state mirror
  logic signed [SW-1:0] sample_ring [TAPS];
  int unsigned          ring_wr;
  int unsigned          dec_phase;
  logic signed [SW-1:0] pending_outputs [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_request;
  int unsigned hold_left;
  int unsigned items_sent;
  int unsigned fail_count;
  int unsigned cycle_count;
  logic signed [SW-1:0] want_out;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic longint lowpass_tap(input int unsigned t);
    int unsigned k;
    k = (t > 16) ? 32 - t : t;
    case (k)
      0:  return 56;
      1:  return 195;
      2:  return 199;
      3:  return -166;
      4:  return -762;
      5:  return -928;
      6:  return 0;
      7:  return 1747;
      8:  return 2741;
      9:  return 1178;
      10: return -2954;
      11: return -6675;
      12: return -5320;
      13: return 3969;
      14: return 19151;
      15: return 33449;
      default: return 39309;
    endcase
  endfunction

  // one input into the mirror, queues the decimated output when due
  function automatic void filter_sample(input logic signed [SW-1:0] value);
    longint      acc;
    longint      rounded;
    int unsigned pos;
    sample_ring[ring_wr] = value;
    ring_wr = (ring_wr + 1 >= TAPS) ? 0 : ring_wr + 1;
    if (dec_phase + 1 < FACTOR) begin
      dec_phase++;
      return;
    end
    dec_phase = 0;
    acc = 0;
    pos = ring_wr;
    for (int unsigned t = 0; t < TAPS; t++) begin
      pos = (pos == 0) ? TAPS - 1 : pos - 1;
      acc += lowpass_tap(t) * longint'(sample_ring[pos]);
    end
    rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (rounded > longint'(SAMPLE_MAX)) begin
      pending_outputs.push_back(SAMPLE_MAX);
    end else if (rounded < longint'(SAMPLE_MIN)) begin
      pending_outputs.push_back(SAMPLE_MIN);
    end else begin
      pending_outputs.push_back(rounded[SW-1:0]);
    end
  endfunction

  // called and returns at a falling edge
  task automatic send_sample(input logic signed [SW-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    sample_in_i = value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    filter_sample(value);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // extreme samples whose signs follow the taps, phase aligned so the last one emits
  task automatic send_matched_run(input bit go_high, input int unsigned span);
    logic signed [SW-1:0] v;
    while (dec_phase != 0) send_sample(SW'($urandom_range(0, 15)));
    for (int t = int'(span) - 1; t >= 0; t--) begin
      v = ((lowpass_tap(t) < 0) ^ go_high) ? SAMPLE_MAX : SAMPLE_MIN;
      send_sample(v);
    end
  endtask

  task automatic send_burst();
    burst_kind_e kind;
    int unsigned r;
    int unsigned len;
    r   = $urandom_range(0, 99);
    len = $urandom_range(3, 40);
    if (r < 45) begin
      kind = BURST_UNIFORM;
    end else if (r < 65) begin
      kind = BURST_EXTREME;
    end else if (r < 80) begin
      kind = BURST_MATCHED;
    end else begin
      kind = BURST_SMALL;
    end
    case (kind)
      BURST_UNIFORM: begin
        repeat (len) send_sample(SW'($urandom));
      end
      BURST_EXTREME: begin
        repeat (len) send_sample($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
      end
      BURST_MATCHED: begin
        send_matched_run($urandom_range(0, 1), $urandom_range(0, 1) ? 21 : TAPS);
      end
      default: begin
        repeat (len) send_sample(SW'(int'($urandom_range(0, 64)) - 32));
      end
    endcase
  endtask

  task automatic test_extremes();
    send_sample(16'sh0000);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    send_sample(16'sh8001);
    send_sample(16'sh7ffe);
    send_sample(16'sd256);
    send_sample(-16'sd256);
    // lone impulse then silence
    send_sample(SAMPLE_MAX);
    repeat (8) send_sample(16'sh0000);
  endtask

  task automatic test_saturation();
    send_matched_run(1'b1, 21);
    send_matched_run(1'b0, 21);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < count) send_burst();
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 400;
    repeat (40) send_sample(SW'($urandom));
    wait_drained();
  endtask

  task automatic test_pause_resume();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    repeat (20) send_sample(SW'($urandom));
    wait_drained();
    repeat (20) send_sample(SW'($urandom));
    wait_drained();
  endtask

  // ready side, with an optional long hold-off
  always @(negedge clk_i) begin
    if (stall_request != 0) begin
      hold_left     = stall_request;
      stall_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected sample_out transfer, actual %0d", $time, sample_out_o);
        fail_count++;
      end else begin
        want_out = pending_outputs.pop_front();
        if (sample_out_o !== want_out) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $time, want_out, sample_out_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d outputs outstanding", $time, pending_outputs.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    sample_in_i   = '0;
    ring_wr       = 0;
    dec_phase     = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 0;
    items_sent    = 0;
    fail_count    = 0;
    cycle_count   = 0;
    for (int i = 0; i < TAPS; i++) sample_ring[i] = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_saturation();
    send_idle_pct = 34;
    recv_idle_pct = 45;
    test_random_traffic(330);
    send_idle_pct = 45;
    recv_idle_pct = 34;
    test_random_traffic(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(250);
    test_backpressure();
    test_pause_resume();

    wait_drained();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
